/* hw/rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// shared sizes, controller states, command and status bundles and the
// signed minimum used by the range minimum query block
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int NODES        = 2 * MAX_ELEMENTS;
    localparam int NODE_W       = $clog2(NODES);
    localparam int LH_W         = NODE_W + 1;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int LEN_W = 11;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
    localparam logic signed [VAL_W-1:0] TOP_VALUE = 32'sh7FFF_FFFF;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_QLO,
        ST_QHI,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic upd_start;
        logic upd_step;
        logic query_load;
        logic q_lo;
        logic q_hi;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic idx_ok;
        logic bad_now;
        logic root;
        logic lo_ge_hi;
        logic out_free;
    } stat_t;

    function automatic logic signed [VAL_W-1:0] lesser(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        return (b < a) ? b : a;
    endfunction

endpackage

/* hw/rtl/rmq_ctrl.sv */
// ----------------------------------------------------------------------------
// rmq_ctrl
// sequencer for the clearing pass, pyramid updates and range walks
// ----------------------------------------------------------------------------
module rmq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tuser,
    output logic           s_tready,
    input  rmq_pkg::stat_t stat,
    output rmq_pkg::cmd_t  cmd
);
    import rmq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == FUNC_QUERY) begin
                        state_next = stat.bad_now ? ST_DONE : ST_QLO;
                    end else if (stat.idx_ok) begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                if (stat.root) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QLO: begin
                state_next = stat.lo_ge_hi ? ST_DONE : ST_QHI;
            end
            ST_QHI: begin
                state_next = ST_QLO;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.query_load = accept && (s_tuser == FUNC_QUERY);
                cmd.upd_start  = accept && (s_tuser == FUNC_WRITE) && stat.idx_ok;
            end
            ST_UPD: begin
                cmd.upd_step = 1'b1;
            end
            ST_QLO: begin
                cmd.q_lo = !stat.lo_ge_hi;
            end
            ST_QHI: begin
                cmd.q_hi = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/rmq_datapath.sv */
// ----------------------------------------------------------------------------
// rmq_datapath
// minima pyramid memory, walk registers, length register and result register
// ----------------------------------------------------------------------------
module rmq_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rmq_pkg::cmd_t                        cmd,
    output rmq_pkg::stat_t                       stat,
    input  logic [rmq_pkg::IDX_W-1:0]            element_index,
    input  logic signed [rmq_pkg::VAL_W-1:0]     element_value,
    input  logic [rmq_pkg::IDX_W-1:0]            range_left,
    input  logic [rmq_pkg::IDX_W-1:0]            range_right,
    input  logic                                 cfg_wr_en,
    input  logic [rmq_pkg::LEN_W-1:0]            cfg_wr_data,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic signed [rmq_pkg::VAL_W-1:0]     range_minimum,
    output logic                                 bad_range
);
    import rmq_pkg::*;

    logic signed [VAL_W-1:0] mem [0:NODES-1];
    logic signed [VAL_W-1:0] rd_data_reg;

    logic                    wr_en;
    logic [NODE_W-1:0]       wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic [NODE_W-1:0]       rd_addr;

    logic [NODE_W-1:0]       clr_reg, clr_next;
    logic [NODE_W-1:0]       node_reg, node_next;
    logic signed [VAL_W-1:0] cur_reg, cur_next;
    logic [LH_W-1:0]         lo_reg, lo_next;
    logic [LH_W-1:0]         hi_reg, hi_next;
    logic signed [VAL_W-1:0] best_reg, best_next;
    logic                    pend_reg, pend_next;
    logic                    bad_reg, bad_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0] out_min_reg, out_min_next;
    logic                    out_bad_reg, out_bad_next;

    logic [NODE_W-1:0]       leaf;
    logic [NODE_W-1:0]       parent;
    logic signed [VAL_W-1:0] upd_min;

    assign leaf    = NODE_W'(MAX_ELEMENTS) + NODE_W'(element_index);
    assign parent  = node_reg >> 1;
    assign upd_min = lesser(cur_reg, rd_data_reg);

    assign stat.clr_last = (clr_reg == NODE_W'(NODES - 1));
    assign stat.idx_ok   = (LH_W'(element_index) < LH_W'(MAX_ELEMENTS));
    assign stat.bad_now  = (range_left > range_right)
                        || (LEN_W'(range_right) >= len_reg)
                        || (LH_W'(range_right) >= LH_W'(MAX_ELEMENTS));
    assign stat.root     = (parent == NODE_W'(1));
    assign stat.lo_ge_hi = (lo_reg >= hi_reg);
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign range_minimum = out_min_reg;
    assign bad_range     = out_bad_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        wr_en          = 1'b0;
        wr_addr        = clr_reg;
        wr_data        = TOP_VALUE;
        rd_addr        = lo_reg[NODE_W-1:0];
        clr_next       = clr_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        bad_next       = bad_reg;
        pend_next      = 1'b0;
        best_next      = pend_reg ? lesser(best_reg, rd_data_reg) : best_reg;
        len_next       = cfg_wr_en ? cfg_wr_data : len_reg;
        out_min_next   = out_min_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;

        if (cmd.clr_step) begin
            wr_en    = 1'b1;
            clr_next = clr_reg + NODE_W'(1);
        end

        if (cmd.upd_start) begin
            wr_en     = 1'b1;
            wr_addr   = leaf;
            wr_data   = element_value;
            rd_addr   = leaf ^ NODE_W'(1);
            node_next = leaf;
            cur_next  = element_value;
        end

        // one level per cycle: write the parent, fetch the parent's sibling
        if (cmd.upd_step) begin
            wr_en     = 1'b1;
            wr_addr   = parent;
            wr_data   = upd_min;
            rd_addr   = parent ^ NODE_W'(1);
            node_next = parent;
            cur_next  = upd_min;
        end

        if (cmd.query_load) begin
            lo_next   = LH_W'(MAX_ELEMENTS) + LH_W'(range_left);
            hi_next   = LH_W'(MAX_ELEMENTS) + LH_W'(range_right) + LH_W'(1);
            best_next = TOP_VALUE;
            bad_next  = stat.bad_now;
        end

        if (cmd.q_lo && lo_reg[0]) begin
            rd_addr   = lo_reg[NODE_W-1:0];
            lo_next   = lo_reg + LH_W'(1);
            pend_next = 1'b1;
        end

        if (cmd.q_hi) begin
            if (hi_reg[0]) begin
                rd_addr   = hi_reg[NODE_W-1:0] ^ NODE_W'(1);
                pend_next = 1'b1;
            end
            lo_next = lo_reg >> 1;
            hi_next = hi_reg >> 1;
        end

        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_min_next   = bad_reg ? '0 : best_reg;
            out_bad_next   = bad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            len_reg       <= LEN_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        cur_reg     <= cur_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        best_reg    <= best_next;
        bad_reg     <= bad_next;
        out_min_reg <= out_min_next;
        out_bad_reg <= out_bad_next;
    end

endmodule

/* hw/rtl/range_minimum_query.sv */
// ----------------------------------------------------------------------------
// range_minimum_query
// range minimum over a stored array of signed 32-bit values, kept as a
// bottom-up pyramid of pairwise minima in one single-port-write memory
//
// s_ channel: one request per item; s_tuser selects write (0) or query (1).
// a write stores one element and refreshes every minimum above it, one
// pyramid level per cycle; it gives no result.
// a query walks the pyramid level by level, a low step and a high step with
// at most one memory read each, and gives one result on the m_ channel; a
// rejected range skips the walk and is answered with m_tuser high and
// m_tdata zero.
// one item is in flight at a time; the result sits in an output register,
// so the next item is accepted while the result waits. a stalled receiver
// holds a finished query until the register is free.
// cfg_wr_en writes array_length (bounds check only) at any idle time.
// after reset a clearing pass writes the largest positive value to all
// 2 * MAX_ELEMENTS nodes with s_tready low.
// ----------------------------------------------------------------------------
module range_minimum_query (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // element_index, element_value, range_left, range_right, zero fill
    input  logic [63:0]                   s_tdata,
    // func
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // range_minimum
    output logic [31:0]                   m_tdata,
    // bad_range
    output logic                          m_tuser,
    input  logic                          cfg_wr_en,
    input  logic [rmq_pkg::LEN_W-1:0]     cfg_wr_data
);
    import rmq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic signed [VAL_W-1:0] range_minimum;

    rmq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rmq_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .element_index (s_tdata[9:0]),
        .element_value ($signed(s_tdata[41:10])),
        .range_left    (s_tdata[51:42]),
        .range_right   (s_tdata[61:52]),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .range_minimum (range_minimum),
        .bad_range     (m_tuser)
    );

    assign m_tdata = $unsigned(range_minimum);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks range_minimum_query against an element-level model of the stored
// array: writes update the model, queries are answered by a direct scan of
// the inclusive range, and every result request is compared in order. runs
// phases over several array lengths with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import rmq_pkg::*;

    typedef struct {
        logic        func;
        logic [9:0]  index;
        logic [31:0] value;
        logic [9:0]  first_idx;
        logic [9:0]  last_idx;
    } rmq_request_t;

    typedef struct {
        logic signed [31:0] minimum;
        logic               bad;
    } rmq_answer_t;

    logic              aclk;
    logic              aresetn     = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata     = '0;
    logic              s_tuser     = 1'b0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [31:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]  cfg_wr_data = '0;

    rmq_request_t       pending_requests[$];
    rmq_answer_t        expected_answers[$];
    logic signed [31:0] element_store[MAX_ELEMENTS];
    logic [LEN_W-1:0]   length_setting;
    int unsigned        requests_queued = 0;
    int unsigned        requests_taken  = 0;
    int                 send_idle_pct   = 0;
    int                 recv_idle_pct   = 0;
    int                 error_count     = 0;

    range_minimum_query DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // request driver, with the model updated on every accepted request
    always @(posedge aclk) begin : request_driver
        rmq_request_t       req;
        rmq_answer_t        ans;
        logic [9:0]         q_first;
        logic [9:0]         q_last;
        logic signed [31:0] best;
        int                 n;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser == FUNC_WRITE) begin
                    element_store[s_tdata[9:0]] = s_tdata[41:10];
                end else begin
                    q_first = s_tdata[51:42];
                    q_last  = s_tdata[61:52];
                    if (q_first > q_last || {1'b0, q_last} >= length_setting) begin
                        ans.minimum = '0;
                        ans.bad     = 1'b1;
                    end else begin
                        best = TOP_VALUE;
                        for (n = q_first; n <= q_last; n++) begin
                            if (element_store[n] < best) best = element_store[n];
                        end
                        ans.minimum = best;
                        ans.bad     = 1'b0;
                    end
                    expected_answers = {expected_answers, ans};
                end
                requests_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    s_tuser  <= req.func;
                    s_tdata  <= {2'b00, req.last_idx, req.first_idx, req.value, req.index};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        rmq_answer_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual minimum %0d bad %b",
                             $time, $signed(m_tdata), m_tuser);
                    error_count++;
                end else begin
                    want = expected_answers.pop_front();
                    if (m_tdata !== want.minimum) begin
                        $display("%0t: range_minimum mismatch, expected %0d, actual %0d",
                                 $time, want.minimum, $signed(m_tdata));
                        error_count++;
                    end
                    if (m_tuser !== want.bad) begin
                        $display("%0t: bad_range mismatch, expected %b, actual %b",
                                 $time, want.bad, m_tuser);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic add_request(input logic func, input logic [9:0] index,
                               input logic [31:0] value, input logic [9:0] first_idx,
                               input logic [9:0] last_idx);
        rmq_request_t req;
        req.func      = func;
        req.index     = index;
        req.value     = value;
        req.first_idx = first_idx;
        req.last_idx  = last_idx;
        pending_requests = {pending_requests, req};
        requests_queued++;
    endtask

    task automatic add_write(input logic [9:0] index, input logic [31:0] value);
        add_request(FUNC_WRITE, index, value, 10'($urandom), 10'($urandom));
    endtask

    task automatic add_query(input logic [9:0] first_idx, input logic [9:0] last_idx);
        add_request(FUNC_QUERY, 10'($urandom), $urandom, first_idx, last_idx);
    endtask

    task automatic wait_drained();
        while (requests_taken != requests_queued || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic start_phase(input logic [LEN_W-1:0] len, input int send_pct,
                               input int recv_pct);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        length_setting = len;
        send_idle_pct  = send_pct;
        recv_idle_pct  = recv_pct;
    endtask

    task automatic add_random(input int count);
        int          k;
        int          span;
        int          lim;
        logic [9:0]  q_first;
        logic [9:0]  q_last;
        logic [9:0]  index;
        logic [31:0] value;
        lim = (length_setting == 0) ? 1 : ((length_setting > MAX_ELEMENTS) ? MAX_ELEMENTS
                                                                              : length_setting);
        for (k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = $urandom_range(31) - 16;
                default: value = $urandom;
            endcase
            if ($urandom_range(1) == 0) begin
                index = ($urandom_range(9) < 7) ? 10'($urandom_range(lim - 1))
                                                : 10'($urandom_range(1023));
                add_write(index, value);
            end else if ($urandom_range(9) < 8) begin
                q_last  = 10'($urandom_range(lim - 1));
                span    = ($urandom_range(3) == 0) ? q_last : ((q_last < 40) ? q_last : 40);
                q_first = q_last - 10'($urandom_range(span));
                add_query(q_first, q_last);
            end else begin
                add_query(10'($urandom), 10'($urandom));
            end
        end
    endtask

    initial begin
        for (int n = 0; n < MAX_ELEMENTS; n++) element_store[n] = TOP_VALUE;
        length_setting = LEN_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        // clearing pass holds s_tready low
        while (!s_tready) @(posedge aclk);

        start_phase(11'd1024, 30, 87);
        add_query(10'd0, 10'd1023);
        add_write(10'd0, 32'h8000_0000);
        add_write(10'd1023, 32'h7FFF_FFFF);
        add_write(10'd512, 32'h0000_0000);
        add_write(10'd1, 32'hFFFF_FFFF);
        add_write(10'd1022, 32'h5555_5555);
        add_write(10'd341, 32'hAAAA_AAAA);
        add_query(10'd0, 10'd0);
        add_query(10'd1023, 10'd1023);
        add_query(10'd1, 10'd1022);
        add_query(10'd0, 10'd1023);
        add_query(10'd342, 10'd1023);
        // never written elements read as the top value
        add_query(10'd513, 10'd1021);
        add_query(10'd5, 10'd4);
        add_query(10'd1023, 10'd0);
        add_query(10'd1022, 10'd1023);
        add_random(80);

        start_phase(11'd1, 87, 30);
        add_query(10'd0, 10'd0);
        add_query(10'd0, 10'd1);
        add_write(10'd0, 32'h0000_0007);
        add_query(10'd0, 10'd0);
        add_random(60);

        // zero length rejects every query
        start_phase(11'd0, 0, 0);
        add_query(10'd0, 10'd0);
        add_random(40);

        // length above the store size acts as the full store
        start_phase(11'd2047, 30, 87);
        add_query(10'd0, 10'd1023);
        add_random(100);

        start_phase(LEN_W'($urandom_range(1023, 2)), 87, 30);
        add_random(100);

        start_phase(11'd1024, 0, 0);
        add_random(120);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_ctrl.sv
hw/rtl/rmq_datapath.sv
hw/rtl/range_minimum_query.sv
tb/testbench.sv
